// ----- src/pvtrq_pkg.sv -----
// Shared types and codes for the persistent value tree range query block.
// Depends on nothing; used by persistent_value_tree_range_query.
package pvtrq_pkg;

    // Request codes carried in the low bits of the input item.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_KTH    = 2'd1;
    localparam logic [1:0] ACT_COUNT  = 2'd2;
    localparam logic [1:0] ACT_XOR    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_ROOT,
        S_INS_RD,
        S_INS_WR,
        S_Q_ROOTY,
        S_Q_NX,
        S_Q_NY,
        S_Q_CHK,
        S_Q_LVL,
        S_Q_END,
        S_DONE
    } state_t;

endpackage

// ----- src/persistent_value_tree_range_query.sv -----
// Persistent counting tree with k-th smallest, count-at-most and max-xor range queries.
// Depends on pvtrq_pkg for request codes and the sequencer state type.
//
// The block keeps an append-only sequence of values as a persistent binary counting tree.
// An insert copies the VALUE_BITS+1 nodes on the value's path into fresh node slots, so every
// prefix of the sequence keeps its own root. A query over positions range_start..range_end walks
// the roots of versions range_end and range_start-1 side by side from the top bit down. All
// state sits in two synchronous memories (nodes and version roots), each with one write port
// and one registered read port, and every step of the walk is a dependent memory read, which
// sets the rate. An insert accepts the request, reads the old root, then reads and writes each
// copied node in turn and hands the result to the output register. A query reads both roots and
// both top nodes, then for each level reads four children and decides, then finishes at the leaf
// and hands off. A request refused on its range or on a full sequence goes straight to hand-off;
// a rank of zero or one too large, or a bound that covers every value, stops after the root and
// node reads. Each of these is stretched while the output register still holds an unaccepted
// result when the block wants to hand over a new one. One item is worked at a time; the next
// item is accepted as soon as the sequencer is idle, even while the previous result still waits
// in the output register. Node slot zero and root slot zero read as zero through a registered
// address flag, so no clearing pass is needed after reset. Errors (sequence full, bad or empty
// range, rank out of range) return error=1 with answer=0 and leave the state unchanged.
module persistent_value_tree_range_query #(
    parameter int VALUE_BITS = 19,
    parameter int MAX_ITEMS  = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0 up: action, value, range_start, range_end, zero fill.
    input  logic [((2 + VALUE_BITS + 2 * $clog2(MAX_ITEMS + 1) + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // Fields from bit 0 up: answer, error, zero fill.
    output logic [((VALUE_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int VB   = VALUE_BITS;
    localparam int RW   = $clog2(MAX_ITEMS + 1);
    localparam int CW   = RW;
    localparam int ND   = 1 + MAX_ITEMS * (VB + 1);
    localparam int AW   = $clog2(ND);
    localparam int NW   = CW + 2 * AW;
    localparam int LW   = $clog2(VB + 1);
    localparam int KIW  = $clog2(VB);
    localparam int WW   = ((VB > CW) ? VB : CW) + 1;
    localparam int IBW  = ((2 + VB + 2 * RW + 7) / 8) * 8;
    localparam int OBW  = ((VB + 1 + 7) / 8) * 8;

    // Input fields.
    logic [1:0]    in_action;
    logic [VB-1:0] in_value;
    logic [RW-1:0] in_start;
    logic [RW-1:0] in_end;
    assign in_action = s_tdata[1:0];
    assign in_value  = s_tdata[2 +: VB];
    assign in_start  = s_tdata[2 + VB +: RW];
    assign in_end    = s_tdata[2 + VB + RW +: RW];

    // Memories.
    logic [NW-1:0] node_mem [ND];
    logic [AW-1:0] root_mem [MAX_ITEMS + 1];

    logic [AW-1:0] node_raddr;
    logic          node_we;
    logic [AW-1:0] node_waddr;
    logic [NW-1:0] node_wdata;
    logic [NW-1:0] node_rdata_reg;
    logic          node_rzero_reg;
    logic [NW-1:0] node_rd;

    logic [RW-1:0] root_raddr;
    logic          root_we;
    logic [RW-1:0] root_waddr;
    logic [AW-1:0] root_wdata;
    logic [AW-1:0] root_rdata_reg;
    logic          root_rzero_reg;
    logic [AW-1:0] root_rd;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (root_we)
        begin
            root_mem[root_waddr] <= root_wdata;
        end
        root_rdata_reg <= root_mem[root_raddr];
    end

    // Slot zero of either memory is the empty node or the empty version.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_rzero_reg <= 1'b1;
            root_rzero_reg <= 1'b1;
        end
        else
        begin
            node_rzero_reg <= (node_raddr == '0);
            root_rzero_reg <= (root_raddr == '0);
        end
    end

    assign node_rd = node_rzero_reg ? '0 : node_rdata_reg;
    assign root_rd = root_rzero_reg ? '0 : root_rdata_reg;

    // Control and datapath registers.
    pvtrq_pkg::state_t state_reg, state_next;
    logic [RW-1:0] vc_reg;
    logic [AW-1:0] used_reg;
    logic [1:0]    act_reg;
    logic [VB-1:0] k_reg;
    logic [RW-1:0] le_reg;
    logic [AW-1:0] old_reg;
    logic [AW-1:0] first_reg;
    logic [AW-1:0] xidx_reg;
    logic [AW-1:0] yidx_reg;
    logic [LW-1:0] lvl_reg;
    logic [2:0]    phase_reg;
    logic [NW-1:0] cx_reg, cy_reg, ch0_reg, ch1_reg, ch2_reg;
    logic [VB-1:0] ans_reg;
    logic [CW-1:0] sum_reg;
    logic          err_reg;
    logic          out_valid_reg;
    logic [VB-1:0] out_answer_reg;
    logic          out_error_reg;

    logic          accept;
    logic          ins_full;
    logic          range_bad;
    logic          out_free;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == pvtrq_pkg::S_IDLE);
    assign ins_full  = (vc_reg == RW'(MAX_ITEMS));
    assign range_bad = (in_start == '0) || (in_start > in_end) || (in_end > vc_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // Node field views.
    function automatic logic [CW-1:0] n_cnt(input logic [NW-1:0] n);
        return n[NW-1 -: CW];
    endfunction
    function automatic logic [AW-1:0] n_lc(input logic [NW-1:0] n);
        return n[2*AW-1:AW];
    endfunction
    function automatic logic [AW-1:0] n_rc(input logic [NW-1:0] n);
        return n[AW-1:0];
    endfunction

    // Path bit for the current level: the node at level lvl picks its child by bit lvl-1.
    logic [LW-1:0] lvl_m1;
    logic          kbit;
    assign lvl_m1 = lvl_reg - LW'(1);
    assign kbit   = k_reg[lvl_m1[KIW-1:0]];

    // Insert: the copy of the node just read.
    logic [AW-1:0] new_idx;
    logic [CW-1:0] cp_cnt;
    logic [AW-1:0] cp_lc, cp_rc;
    assign new_idx = used_reg + AW'(1);
    always_comb
    begin
        cp_cnt = n_cnt(node_rd) + CW'(1);
        cp_lc  = n_lc(node_rd);
        cp_rc  = n_rc(node_rd);
        if (lvl_reg != '0)
        begin
            if (kbit)
            begin
                cp_rc = new_idx + AW'(1);
            end
            else
            begin
                cp_lc = new_idx + AW'(1);
            end
        end
    end

    // Query: counts under the two children at the current level.
    logic [CW-1:0] total, left_cnt, right_cnt, leaf_cnt;
    logic [WW-1:0] k_w, left_w;
    logic          go_right;
    assign total     = n_cnt(node_rd) - n_cnt(cx_reg);
    assign left_cnt  = n_cnt(ch1_reg) - n_cnt(ch0_reg);
    assign right_cnt = n_cnt(node_rd) - n_cnt(ch2_reg);
    assign leaf_cnt  = n_cnt(cy_reg) - n_cnt(cx_reg);
    assign k_w       = WW'(k_reg);
    assign left_w    = WW'(left_cnt);
    always_comb
    begin
        case (act_reg)
            pvtrq_pkg::ACT_KTH:   go_right = (k_w > left_w);
            pvtrq_pkg::ACT_COUNT: go_right = kbit;
            pvtrq_pkg::ACT_XOR:   go_right = kbit ? (left_cnt == '0) : (right_cnt != '0);
            default:              go_right = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pvtrq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == pvtrq_pkg::ACT_INSERT)
                    begin
                        state_next = ins_full ? pvtrq_pkg::S_DONE : pvtrq_pkg::S_INS_ROOT;
                    end
                    else
                    begin
                        state_next = range_bad ? pvtrq_pkg::S_DONE : pvtrq_pkg::S_Q_ROOTY;
                    end
                end
            end
            pvtrq_pkg::S_INS_ROOT: state_next = pvtrq_pkg::S_INS_RD;
            pvtrq_pkg::S_INS_RD:   state_next = pvtrq_pkg::S_INS_WR;
            pvtrq_pkg::S_INS_WR:
            begin
                state_next = (lvl_reg == '0) ? pvtrq_pkg::S_DONE : pvtrq_pkg::S_INS_RD;
            end
            pvtrq_pkg::S_Q_ROOTY: state_next = pvtrq_pkg::S_Q_NX;
            pvtrq_pkg::S_Q_NX:    state_next = pvtrq_pkg::S_Q_NY;
            pvtrq_pkg::S_Q_NY:    state_next = pvtrq_pkg::S_Q_CHK;
            pvtrq_pkg::S_Q_CHK:
            begin
                if (act_reg == pvtrq_pkg::ACT_KTH && (k_reg == '0 || k_w > WW'(total)))
                begin
                    state_next = pvtrq_pkg::S_DONE;
                end
                else if (act_reg == pvtrq_pkg::ACT_COUNT && k_reg == '1)
                begin
                    state_next = pvtrq_pkg::S_DONE;
                end
                else
                begin
                    state_next = pvtrq_pkg::S_Q_LVL;
                end
            end
            pvtrq_pkg::S_Q_LVL:
            begin
                if (phase_reg == 3'd4 && lvl_reg == LW'(1))
                begin
                    state_next = pvtrq_pkg::S_Q_END;
                end
            end
            pvtrq_pkg::S_Q_END: state_next = pvtrq_pkg::S_DONE;
            pvtrq_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = pvtrq_pkg::S_IDLE;
                end
            end
            default: state_next = pvtrq_pkg::S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        node_raddr = '0;
        node_we    = 1'b0;
        node_waddr = new_idx;
        node_wdata = {cp_cnt, cp_lc, cp_rc};
        root_raddr = '0;
        root_we    = 1'b0;
        root_waddr = vc_reg + RW'(1);
        root_wdata = first_reg;
        case (state_reg)
            pvtrq_pkg::S_IDLE:
            begin
                root_raddr = (in_action == pvtrq_pkg::ACT_INSERT) ? vc_reg
                                                                 : in_start - RW'(1);
            end
            pvtrq_pkg::S_INS_RD: node_raddr = old_reg;
            pvtrq_pkg::S_INS_WR:
            begin
                node_we = 1'b1;
                root_we = (lvl_reg == '0);
            end
            pvtrq_pkg::S_Q_ROOTY: root_raddr = le_reg;
            pvtrq_pkg::S_Q_NX:    node_raddr = xidx_reg;
            pvtrq_pkg::S_Q_NY:    node_raddr = yidx_reg;
            pvtrq_pkg::S_Q_LVL:
            begin
                case (phase_reg)
                    3'd0:    node_raddr = n_lc(cx_reg);
                    3'd1:    node_raddr = n_lc(cy_reg);
                    3'd2:    node_raddr = n_rc(cx_reg);
                    3'd3:    node_raddr = n_rc(cy_reg);
                    default: node_raddr = '0;
                endcase
            end
            default:
            begin
                node_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pvtrq_pkg::S_IDLE;
            vc_reg        <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pvtrq_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == pvtrq_pkg::S_INS_WR)
            begin
                used_reg <= new_idx;
                if (lvl_reg == '0)
                begin
                    vc_reg <= vc_reg + RW'(1);
                end
            end
        end
    end

    logic [WW-1:0] sum_w;
    assign sum_w = WW'(sum_reg);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pvtrq_pkg::S_IDLE:
            begin
                act_reg <= in_action;
                k_reg   <= in_value;
                le_reg  <= in_end;
                ans_reg <= '0;
                sum_reg <= '0;
                lvl_reg <= LW'(VB);
                err_reg <= (in_action == pvtrq_pkg::ACT_INSERT) ? ins_full : range_bad;
            end
            pvtrq_pkg::S_INS_ROOT:
            begin
                old_reg   <= root_rd;
                first_reg <= new_idx;
            end
            pvtrq_pkg::S_INS_WR:
            begin
                old_reg <= kbit ? n_rc(node_rd) : n_lc(node_rd);
                lvl_reg <= lvl_m1;
            end
            pvtrq_pkg::S_Q_ROOTY: xidx_reg <= root_rd;
            pvtrq_pkg::S_Q_NX:    yidx_reg <= root_rd;
            pvtrq_pkg::S_Q_NY:    cx_reg   <= node_rd;
            pvtrq_pkg::S_Q_CHK:
            begin
                cy_reg    <= node_rd;
                phase_reg <= 3'd0;
                if (act_reg == pvtrq_pkg::ACT_KTH && (k_reg == '0 || k_w > WW'(total)))
                begin
                    err_reg <= 1'b1;
                end
                if (act_reg == pvtrq_pkg::ACT_COUNT && k_reg == '1)
                begin
                    sum_reg <= total;
                end
            end
            pvtrq_pkg::S_Q_LVL:
            begin
                case (phase_reg)
                    3'd1:    ch0_reg <= node_rd;
                    3'd2:    ch1_reg <= node_rd;
                    3'd3:    ch2_reg <= node_rd;
                    default: ch0_reg <= ch0_reg;
                endcase
                if (phase_reg == 3'd4)
                begin
                    phase_reg <= 3'd0;
                    lvl_reg   <= lvl_m1;
                    if (go_right)
                    begin
                        cx_reg <= ch2_reg;
                        cy_reg <= node_rd;
                        if (act_reg != pvtrq_pkg::ACT_COUNT)
                        begin
                            ans_reg[lvl_m1[KIW-1:0]] <= 1'b1;
                        end
                        if (act_reg == pvtrq_pkg::ACT_KTH)
                        begin
                            k_reg <= VB'(k_w - left_w);
                        end
                        if (act_reg == pvtrq_pkg::ACT_COUNT)
                        begin
                            sum_reg <= sum_reg + left_cnt;
                        end
                    end
                    else
                    begin
                        cx_reg <= ch0_reg;
                        cy_reg <= ch1_reg;
                    end
                end
                else
                begin
                    phase_reg <= phase_reg + 3'd1;
                end
            end
            pvtrq_pkg::S_Q_END:
            begin
                if (act_reg == pvtrq_pkg::ACT_COUNT)
                begin
                    sum_reg <= sum_reg + leaf_cnt;
                end
            end
            pvtrq_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_error_reg <= err_reg;
                    if (err_reg || act_reg == pvtrq_pkg::ACT_INSERT)
                    begin
                        out_answer_reg <= '0;
                    end
                    else if (act_reg == pvtrq_pkg::ACT_COUNT)
                    begin
                        out_answer_reg <= sum_w[VB-1:0];
                    end
                    else
                    begin
                        out_answer_reg <= ans_reg;
                    end
                end
            end
            default:
            begin
                act_reg <= act_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OBW'({out_error_reg, out_answer_reg});

    // Node slot zero is the shared empty node and is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n) node_we |-> node_waddr != '0)
        else $error("write to the empty node slot");

    // The version count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) vc_reg <= RW'(MAX_ITEMS))
        else $error("version count beyond capacity");

    // Between items every version owns exactly one path of nodes.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pvtrq_pkg::S_IDLE |-> 32'(used_reg) == 32'(vc_reg) * (VB + 1))
        else $error("node allocation out of step with version count");

    // A refused request always reports a zero answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_error_reg |-> out_answer_reg == '0)
        else $error("nonzero answer on error");

endmodule
